[hw/rtl/tcce_pkg.sv]
// Shared types, constants and helpers for the text console cell engine.
`default_nettype none

package tcce_pkg;

   localparam int ROWS    = 25;
   localparam int COLS    = 80;
   localparam int CELLS   = ROWS * COLS;
   localparam int CELL_AW = $clog2(CELLS);

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CELL_W = 16;

   localparam logic [7:0] ATTR_RESET = 8'h07;
   localparam logic [7:0] BLANK_CODE = 8'h20;
   localparam logic [7:0] CODE_NL    = 8'h0A;
   localparam logic [7:0] CODE_CR    = 8'h0D;

   localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
   localparam logic [2:0] OP_SET_CURSOR = 3'd1;
   localparam logic [2:0] OP_CLEAR      = 3'd2;
   localparam logic [2:0] OP_WRITE_AT   = 3'd3;
   localparam logic [2:0] OP_READ_CELL  = 3'd4;

   typedef struct packed {
      logic [2:0]       op;
      logic [7:0]       char_code;
      logic [ROW_W-1:0] row_pos;
      logic [COL_W-1:0] col_pos;
      logic [7:0]       cell_attr;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_value;
      logic [ROW_W-1:0]  cur_row;
      logic [COL_W-1:0]  cur_col;
   } rsp_type;

   typedef struct packed {
      logic               en;
      logic [CELL_AW-1:0] addr;
      logic [CELL_W-1:0]  data;
   } mem_wr_type;

   // Linear cell index of a row and column; only meaningful for on-screen positions.
   function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
      logic [CELL_AW:0] full;
      full = (CELL_AW+1)'(row) * (CELL_AW+1)'(COLS) + (CELL_AW+1)'(col);
      return full[CELL_AW-1:0];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/tcce_cell_store.sv]
// Character cell memory: one write port and one registered read port.
`default_nettype none

module tcce_cell_store (
   input  wire logic                               clock,
   input  wire tcce_pkg::mem_wr_type               wr,
   input  wire logic                               rd_en,
   input  wire logic [tcce_pkg::CELL_AW-1:0]       rd_addr,
   output logic      [tcce_pkg::CELL_W-1:0]        rd_data
);

   logic [tcce_pkg::CELL_W-1:0] mem [tcce_pkg::CELLS];
   logic [tcce_pkg::CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/text_console_cell_engine_unit.sv]
// Teletype engine over an 80x25 character cell store, top level.
//
// Commands arrive as beats on the req channel (valid/stall) and each one
// produces exactly one beat on the rsp channel carrying the read cell value
// (zero unless the command is a cell read) and the cursor after the command.
// The csr port writes the current text attribute; write it only while idle.
// A put char, set cursor, write at position or read cell passes from acceptance
// through the done state, where its result goes into the output register, and
// the next command is taken after it returns to idle. A newline or a wrap off
// the last row scrolls the store: one cell is moved per cycle through the
// single memory port pair, then the bottom row is blanked. A clear writes one
// cell per cycle. These walks over the cell memory set the rate of those
// commands.
// After reset a clearing pass writes zero to all 2000 cells, one per cycle,
// and req_stall stays high until it is done.
// Commands are taken one at a time; req_stall is high while one is in work.
// A result waiting under rsp_stall sits in an output register, so the next
// command is still taken, but its own result waits until the slot frees.
`default_nettype none

module text_console_cell_engine_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tcce_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tcce_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_write_enable,
   input  wire logic [7:0]        csr_write_data
);

   typedef enum logic [5:0] {
      ST_INIT   = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SCROLL = 6'b000100,
      ST_FILL   = 6'b001000,
      ST_DONE   = 6'b010000,
      ST_SPARE  = 6'b100000
   } state_type;

   localparam logic [tcce_pkg::CELL_AW-1:0] LAST_CELL  = tcce_pkg::CELL_AW'(tcce_pkg::CELLS - 1);
   localparam logic [tcce_pkg::CELL_AW-1:0] MOVE_END   =
      tcce_pkg::CELL_AW'(tcce_pkg::CELLS - tcce_pkg::COLS);
   localparam logic [tcce_pkg::CELL_AW-1:0] ROW_STRIDE = tcce_pkg::CELL_AW'(tcce_pkg::COLS);
   localparam logic [tcce_pkg::ROW_W-1:0]   LAST_ROW   = tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1);
   localparam logic [tcce_pkg::COL_W-1:0]   LAST_COL   = tcce_pkg::COL_W'(tcce_pkg::COLS - 1);

   state_type                          state_ff, state_in;
   logic [tcce_pkg::CELL_AW-1:0]       cnt_ff, cnt_in;
   logic [tcce_pkg::ROW_W-1:0]         cur_row_ff, cur_row_in;
   logic [tcce_pkg::COL_W-1:0]         cur_col_ff, cur_col_in;
   logic [7:0]                         attr_ff, attr_in;
   logic                               wb_valid_ff, wb_valid_in;
   logic [tcce_pkg::CELL_AW-1:0]       wb_addr_ff, wb_addr_in;
   logic                               read_hit_ff, read_hit_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   tcce_pkg::rsp_type                  rsp_ff, rsp_in;

   tcce_pkg::mem_wr_type               mem_wr;
   logic                               rd_en;
   logic [tcce_pkg::CELL_AW-1:0]       rd_addr;
   logic [tcce_pkg::CELL_W-1:0]        rd_data;

   logic                               accept;
   logic                               req_inside;
   logic                               slot_free;
   logic [tcce_pkg::CELL_W-1:0]        blank_cell;

   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign req_inside = (req_payload.row_pos < tcce_pkg::ROW_W'(tcce_pkg::ROWS)) &&
                       (req_payload.col_pos < tcce_pkg::COL_W'(tcce_pkg::COLS));
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign blank_cell = {attr_ff, tcce_pkg::BLANK_CODE};
   assign attr_in    = csr_write_enable ? csr_write_data : attr_ff;

   tcce_cell_store u_store (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      wb_valid_in = 1'b0;
      wb_addr_in  = wb_addr_ff;
      read_hit_in = read_hit_ff;
      mem_wr      = '0;
      rd_en       = 1'b0;
      rd_addr     = cnt_ff + ROW_STRIDE;

      unique case (state_ff)
         ST_INIT: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = cnt_ff;
            mem_wr.data = '0;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               state_in    = ST_DONE;
               read_hit_in = 1'b0;
               cnt_in      = '0;
               unique case (req_payload.op)
                  tcce_pkg::OP_PUT_CHAR: begin
                     if (req_payload.char_code == tcce_pkg::CODE_NL) begin
                        cur_col_in = '0;
                        if (cur_row_ff == LAST_ROW) begin
                           state_in = ST_SCROLL;
                        end else begin
                           cur_row_in = cur_row_ff + 1'b1;
                        end
                     end else if (req_payload.char_code == tcce_pkg::CODE_CR) begin
                        cur_col_in = '0;
                     end else begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = tcce_pkg::cell_addr(cur_row_ff, cur_col_ff);
                        mem_wr.data = {attr_ff, req_payload.char_code};
                        if (cur_col_ff == LAST_COL) begin
                           cur_col_in = '0;
                           if (cur_row_ff == LAST_ROW) begin
                              state_in = ST_SCROLL;
                           end else begin
                              cur_row_in = cur_row_ff + 1'b1;
                           end
                        end else begin
                           cur_col_in = cur_col_ff + 1'b1;
                        end
                     end
                  end
                  tcce_pkg::OP_SET_CURSOR: begin
                     cur_row_in = (req_payload.row_pos > LAST_ROW) ? LAST_ROW
                                                                   : req_payload.row_pos;
                     cur_col_in = (req_payload.col_pos > LAST_COL) ? LAST_COL
                                                                   : req_payload.col_pos;
                  end
                  tcce_pkg::OP_CLEAR: begin
                     cur_row_in = '0;
                     cur_col_in = '0;
                     state_in   = ST_FILL;
                  end
                  tcce_pkg::OP_WRITE_AT: begin
                     mem_wr.en   = req_inside;
                     mem_wr.addr = tcce_pkg::cell_addr(req_payload.row_pos,
                                                       req_payload.col_pos);
                     mem_wr.data = {req_payload.cell_attr, req_payload.char_code};
                  end
                  tcce_pkg::OP_READ_CELL: begin
                     rd_en       = req_inside;
                     rd_addr     = tcce_pkg::cell_addr(req_payload.row_pos,
                                                       req_payload.col_pos);
                     read_hit_in = req_inside;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCROLL: begin
            // Each cell is read one row down and written back on the next cycle.
            mem_wr.en   = wb_valid_ff;
            mem_wr.addr = wb_addr_ff;
            mem_wr.data = rd_data;
            if (cnt_ff < MOVE_END) begin
               rd_en       = 1'b1;
               wb_valid_in = 1'b1;
               wb_addr_in  = cnt_ff;
               cnt_in      = cnt_ff + 1'b1;
            end else begin
               state_in = ST_FILL;
            end
         end

         ST_FILL: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = cnt_ff;
            mem_wr.data = blank_cell;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if ((state_ff == ST_DONE) && slot_free) begin
         rsp_valid_in      = 1'b1;
         rsp_in.cell_value = read_hit_ff ? rd_data : '0;
         rsp_in.cur_row    = cur_row_ff;
         rsp_in.cur_col    = cur_col_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         attr_ff      <= tcce_pkg::ATTR_RESET;
         wb_valid_ff  <= 1'b0;
         read_hit_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         attr_ff      <= attr_in;
         wb_valid_ff  <= wb_valid_in;
         read_hit_ff  <= read_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff <= wb_addr_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
